### src/rcut_pkg.sv
// Shared constants, types and queue entry layout for the rod cutting optimizer.
// No dependencies; every other file of the block imports this package.
package rcut_pkg;

  // Longest rod and widest price handled by the block.
  localparam int MAX_LEN     = 32;
  localparam int PRICE_BITS  = 16;
  localparam int MAX_RESULTS = 32;

  // Fixed port widths.
  localparam int PORT_IDX_W   = 6;
  localparam int PORT_VAL_W   = 16;
  localparam int PORT_LEN_W   = 6;
  localparam int REV_W        = 21;
  localparam int PORT_PIECE_W = 6;

  // Derived internal widths.
  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);
  localparam int SUM_W = ((PRICE_BITS > REV_W) ? PRICE_BITS : REV_W) + 1;

  localparam logic [REV_W-1:0] REV_MAX = '1;

  // Command queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_SOLVE = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                  cmd;
    logic [IDX_W-1:0]      pidx;
    logic [PRICE_BITS-1:0] pval;
    logic [LEN_W-1:0]      len;
  } q_entry_t;

endpackage

### src/rcut_front.sv
// Input front end: accepts items, drops out-of-range loads, clamps rod lengths.
// Depends on rcut_pkg for the queue entry type and size constants.
module rcut_front (
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           op_i,
  input  logic [rcut_pkg::PORT_IDX_W-1:0] price_index_i,
  input  logic [rcut_pkg::PORT_VAL_W-1:0] price_value_i,
  input  logic [rcut_pkg::PORT_LEN_W-1:0] rod_length_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output rcut_pkg::q_entry_t             q_entry_o
);
  import rcut_pkg::*;

  logic accept;
  logic idx_ok;
  cmd_e cmd;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cmd        = cmd_e'(op_i);
  assign idx_ok     = (price_index_i != '0) && (32'(price_index_i) <= 32'(MAX_LEN));

  // A load to a nonexistent table slot is taken and then forgotten.
  assign q_push_o = accept && ((cmd == CMD_SOLVE) || idx_ok);

  always_comb begin
    q_entry_o.cmd  = cmd;
    q_entry_o.pidx = IDX_W'(price_index_i - PORT_IDX_W'(1));
    q_entry_o.pval = PRICE_BITS'(price_value_i);
    q_entry_o.len  = (32'(rod_length_i) > 32'(MAX_LEN)) ? LEN_W'(MAX_LEN)
                                                        : LEN_W'(rod_length_i);
  end

endmodule

### src/rcut_fifo.sv
// Short command queue that decouples the front end from the solver engine.
// Depends on rcut_pkg for the entry type and queue depth.
module rcut_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rcut_pkg::q_entry_t entry_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output rcut_pkg::q_entry_t entry_o
);
  import rcut_pkg::*;

  q_entry_t            slot_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == (QPTR_W+1)'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (QPTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

### src/rcut_engine.sv
// Solver engine: price table, bottom-up revenue tables and the cut emitter.
// Depends on rcut_pkg for widths, commands and the queue entry type.
module rcut_engine (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_valid_i,
  input  rcut_pkg::q_entry_t               q_entry_i,
  output logic                             q_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rcut_pkg::REV_W-1:0]        revenue_o,
  output logic [rcut_pkg::PORT_PIECE_W-1:0] piece_length_o,
  output logic                             last_o
);
  import rcut_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CALC  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_EREAD = 3'd3;
  localparam logic [2:0] S_EPUSH = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [PRICE_BITS-1:0] price_q [MAX_LEN];

  // Solution memories, never reset: an entry's value is used only once written.
  logic [REV_W-1:0]      rev_mem [MAX_LEN+1];
  logic [LEN_W-1:0]      cut_mem [MAX_LEN+1];
  logic [REV_W-1:0]      rev_rd_q;
  logic [LEN_W-1:0]      cut_rd_q;
  logic [LEN_W-1:0]      rd_addr;
  logic                  mem_we;

  logic [LEN_W-1:0]      len_q, j_q, i_q, rem_q;
  logic [CNT_W-1:0]      n_q;
  logic [REV_W-1:0]      best_q, best_d, total_q;
  logic [LEN_W-1:0]      cut_q, cut_d;

  // Compare stage, in the cycle after the read issue.
  logic                  cmp_vld_q;
  logic [LEN_W-1:0]      cmp_i_q;
  logic                  rd_zero_q;
  logic [PRICE_BITS-1:0] price_rd_q;
  logic [SUM_W-1:0]      cand;
  logic [REV_W-1:0]      cand_sat;
  logic                  take;

  logic                  out_valid_q, last_q;
  logic [REV_W-1:0]      revenue_q;
  logic [LEN_W-1:0]      piece_q;
  logic                  out_free;
  logic                  emit;

  logic [LEN_W-1:0]      piece;
  logic [LEN_W-1:0]      rem_next;
  logic                  emit_last;

  assign out_free       = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign revenue_o      = revenue_q;
  assign piece_length_o = PORT_PIECE_W'(piece_q);
  assign last_o         = last_q;

  // The output register is loaded by an empty-rod solve or by one emitted piece.
  assign emit = out_free && (((state_q == S_IDLE) && q_valid_i &&
                              (q_entry_i.cmd == CMD_SOLVE) && (q_entry_i.len == '0)) ||
                             (state_q == S_EPUSH));

  always_comb begin
    cand     = SUM_W'(price_rd_q) + SUM_W'(rd_zero_q ? '0 : rev_rd_q);
    cand_sat = (cand > SUM_W'(REV_MAX)) ? REV_MAX : REV_W'(cand);
    take     = cmp_vld_q && ((cmp_i_q == LEN_W'(1)) || (cand_sat > best_q));
    best_d   = take ? cand_sat : best_q;
    cut_d    = take ? cmp_i_q : cut_q;
  end

  always_comb begin
    piece     = ((cut_rd_q == '0) || (cut_rd_q > rem_q)) ? rem_q : cut_rd_q;
    rem_next  = rem_q - piece;
    emit_last = (rem_next == '0) || (n_q + CNT_W'(1) == CNT_W'(MAX_RESULTS));
  end

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    mem_we  = 1'b0;
    rd_addr = rem_q;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          if (q_entry_i.cmd == CMD_LOAD) begin
            q_pop_o = 1'b1;
          end else if (q_entry_i.len == '0) begin
            q_pop_o = out_free;
          end else begin
            q_pop_o = 1'b1;
            state_d = S_CALC;
          end
        end
      end
      S_CALC: begin
        rd_addr = j_q - i_q;
        if (i_q == j_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        mem_we  = 1'b1;
        state_d = (j_q == len_q) ? S_EREAD : S_CALC;
      end
      S_EREAD: begin
        state_d = S_EPUSH;
      end
      S_EPUSH: begin
        if (out_free) begin
          state_d = emit_last ? S_IDLE : S_EREAD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rev_mem[j_q] <= best_d;
      cut_mem[j_q] <= cut_d;
    end
    rev_rd_q <= rev_mem[rd_addr];
    cut_rd_q <= cut_mem[rd_addr];
  end

  // Datapath registers that need no reset.
  always_ff @(posedge clk_i) begin
    price_rd_q <= price_q[IDX_W'(i_q - LEN_W'(1))];
    rd_zero_q  <= (rd_addr == '0);
    cmp_i_q    <= i_q;
    if (cmp_vld_q) begin
      best_q <= best_d;
      cut_q  <= cut_d;
    end
    if (state_q == S_IDLE) begin
      len_q <= q_entry_i.len;
    end
    if (state_q == S_DRAIN && j_q == len_q) begin
      total_q <= best_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmp_vld_q   <= 1'b0;
      j_q         <= '0;
      i_q         <= '0;
      rem_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      revenue_q   <= '0;
      piece_q     <= '0;
      for (int k = 0; k < MAX_LEN; k++) begin
        price_q[k] <= '0;
      end
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= (state_q == S_CALC);
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          j_q <= LEN_W'(1);
          i_q <= LEN_W'(1);
          if (q_valid_i && q_entry_i.cmd == CMD_LOAD) begin
            price_q[q_entry_i.pidx] <= q_entry_i.pval;
          end else if (q_valid_i && q_entry_i.len == '0 && out_free) begin
            revenue_q   <= '0;
            piece_q     <= '0;
            last_q      <= 1'b1;
          end
        end
        S_CALC: begin
          if (i_q != j_q) begin
            i_q <= i_q + LEN_W'(1);
          end
        end
        S_DRAIN: begin
          i_q   <= LEN_W'(1);
          j_q   <= j_q + LEN_W'(1);
          rem_q <= len_q;
          n_q   <= '0;
        end
        S_EPUSH: begin
          if (out_free) begin
            revenue_q   <= total_q;
            piece_q     <= piece;
            last_q      <= emit_last;
            rem_q       <= rem_next;
            n_q         <= n_q + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### src/rod_cutting_optimizer_unit.sv
// Rod cutting optimizer, top level. A load item is written into the price table when it reaches the head of the
// queue with the engine idle; a solve fills the tables at a pace set by the single compare-add unit and the one
// read port of the revenue memory, then emits each piece through a read state and a push state that waits for the
// output. Items are worked one at a time by the engine; the two-entry queue lets the input side keep accepting
// meanwhile. Reset is asynchronous and active low; it clears the price table, the queue and all control state;
// the solution memories are not reset.
module rod_cutting_optimizer_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             op_i,
  input  logic [rcut_pkg::PORT_IDX_W-1:0]   price_index_i,
  input  logic [rcut_pkg::PORT_VAL_W-1:0]   price_value_i,
  input  logic [rcut_pkg::PORT_LEN_W-1:0]   rod_length_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rcut_pkg::REV_W-1:0]        revenue_o,
  output logic [rcut_pkg::PORT_PIECE_W-1:0] piece_length_o,
  output logic                             last_o
);
  import rcut_pkg::*;

  // Front to queue.
  logic     q_push;
  logic     q_full;
  q_entry_t q_entry_in;

  // Queue to engine.
  logic     q_valid;
  logic     q_pop;
  q_entry_t q_entry_out;

  // The front end checks each item: loads outside the price table are dropped here, and
  // solve lengths beyond the longest supported rod are clamped before they are queued.
  rcut_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .price_index_i (price_index_i),
    .price_value_i (price_value_i),
    .rod_length_i  (rod_length_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (q_entry_in)
  );

  rcut_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry_out)
  );

  // The engine retires one queued item at a time. For each length j it issues j reads of
  // the revenue memory with the matching price, compares one candidate per cycle a stage
  // later, and writes the best revenue and first cut in a final drain state. Emission walks the
  // first-cut memory from the full length down, driving a registered output stage.
  rcut_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_entry_i      (q_entry_out),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .revenue_o      (revenue_o),
    .piece_length_o (piece_length_o),
    .last_o         (last_o)
  );

  // The front end must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("command queue pushed while full");

  // A piece of length zero only comes from an empty rod: revenue zero, single last item.
  a_empty_rod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && piece_length_o == '0) |-> (revenue_o == '0 && last_o))
    else $error("zero piece outside an empty-rod solution");

  // Every item that is not last carries a real piece.
  a_nonlast_piece: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (piece_length_o != '0))
    else $error("non-final item with zero piece length");

endmodule

### dv/rod_cutting_optimizer_unit_test.sv
// Testbench for rod_cutting_optimizer_unit: price loads and rod solves are driven, and the
// emitted cut pieces are checked against a bottom-up rod cutting predictor kept in the bench.
// Depends on rcut_pkg and the rod_cutting_optimizer_unit RTL only.
module rod_cutting_optimizer_unit_test;
  import rcut_pkg::*;

  // The slowest legal run is about 230 items, each a full length-32 solve with 32 pieces
  // behind output stalls.
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int RANDOM_ITEMS   = 190;
  localparam int QUIET_ITEMS    = 30;
  localparam int DRAIN_CYCLES   = 100;
  localparam int N_DIRECTED     = 22;

  // One emitted cut piece.
  typedef struct packed {
    logic [REV_W-1:0]        revenue;
    logic [PORT_PIECE_W-1:0] piece;
    logic                    last;
  } cut_piece_t;

  // One input item. For rows marked typed the single result is written out by hand.
  typedef struct packed {
    cmd_e                    op;
    logic [PORT_IDX_W-1:0]   idx;
    logic [PORT_VAL_W-1:0]   val;
    logic [PORT_LEN_W-1:0]   len;
    logic                    typed;
    logic [REV_W-1:0]        want_rev;
    logic [PORT_PIECE_W-1:0] want_piece;
    logic                    want_last;
  } rod_item_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    op_i;
  logic [PORT_IDX_W-1:0]   price_index_i;
  logic [PORT_VAL_W-1:0]   price_value_i;
  logic [PORT_LEN_W-1:0]   rod_length_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [REV_W-1:0]        revenue_o;
  logic [PORT_PIECE_W-1:0] piece_length_o;
  logic                    last_o;

  // Bench copy of the block state. Index 0 of the price copy is never used.
  logic [PRICE_BITS-1:0]   price_copy [1:MAX_LEN];
  logic [REV_W-1:0]        best_rev   [0:MAX_LEN];
  logic [PORT_PIECE_W-1:0] best_cut   [0:MAX_LEN];

  cut_piece_t pending_cuts [$];

  int  cycle_count  = 0;
  int  error_count  = 0;
  int  loads_sent   = 0;
  int  ignored_sent = 0;
  int  solves_sent  = 0;
  int  pieces_seen  = 0;
  int  gap_pct      = 0;
  int  stall_pct    = 0;
  bit  quiet        = 1'b0;

  // Directed items. Rows whose result is obvious carry it inline; the rest go through
  // the predictor. Prices are all zero right after reset.
  rod_item_t directed_rows [N_DIRECTED] = '{
    // Empty rod: one piece of length 0 with revenue 0.
    '{CMD_SOLVE, 6'd0,  16'd0,     6'd0,  1'b1, 21'd0,     6'd0,  1'b1},
    // All prices zero: every cut ties, so the smallest first cut wins.
    '{CMD_SOLVE, 6'd0,  16'd0,     6'd1,  1'b1, 21'd0,     6'd1,  1'b1},
    '{CMD_SOLVE, 6'd0,  16'd0,     6'd3,  1'b0, 21'd0,     6'd0,  1'b0},
    '{CMD_LOAD,  6'd1,  16'hFFFF,  6'd0,  1'b0, 21'd0,     6'd0,  1'b0},
    '{CMD_SOLVE, 6'd0,  16'd0,     6'd1,  1'b1, 21'd65535, 6'd1,  1'b1},
    '{CMD_LOAD,  6'd32, 16'hFFFF,  6'd0,  1'b0, 21'd0,     6'd0,  1'b0},
    // Loads to index 0 and above the top length leave the table alone.
    '{CMD_LOAD,  6'd0,  16'd1234,  6'd0,  1'b0, 21'd0,     6'd0,  1'b0},
    '{CMD_LOAD,  6'd33, 16'd7,     6'd0,  1'b0, 21'd0,     6'd0,  1'b0},
    '{CMD_LOAD,  6'd63, 16'hFFFF,  6'd63, 1'b0, 21'd0,     6'd0,  1'b0},
    // Thirty-two unit pieces at full price: the largest revenue the block can give.
    '{CMD_SOLVE, 6'd0,  16'd0,     6'd32, 1'b0, 21'd0,     6'd0,  1'b0},
    // Rod lengths above the top saturate to the top length.
    '{CMD_SOLVE, 6'd0,  16'd0,     6'd33, 1'b0, 21'd0,     6'd0,  1'b0},
    '{CMD_SOLVE, 6'd63, 16'hFFFF,  6'd63, 1'b0, 21'd0,     6'd0,  1'b0},
    '{CMD_LOAD,  6'd1,  16'd0,     6'd0,  1'b0, 21'd0,     6'd0,  1'b0},
    // Only the whole rod has a price now, so one piece of length 32 comes out.
    '{CMD_SOLVE, 6'd0,  16'd0,     6'd32, 1'b1, 21'd65535, 6'd32, 1'b1},
    '{CMD_LOAD,  6'd2,  16'd10,    6'd0,  1'b0, 21'd0,     6'd0,  1'b0},
    '{CMD_LOAD,  6'd4,  16'd20,    6'd0,  1'b0, 21'd0,     6'd0,  1'b0},
    '{CMD_LOAD,  6'd3,  16'd14,    6'd0,  1'b0, 21'd0,     6'd0,  1'b0},
    // Two pieces of 2 tie with one piece of 4.
    '{CMD_SOLVE, 6'd0,  16'd0,     6'd4,  1'b0, 21'd0,     6'd0,  1'b0},
    '{CMD_SOLVE, 6'd0,  16'd0,     6'd7,  1'b0, 21'd0,     6'd0,  1'b0},
    '{CMD_LOAD,  6'd32, 16'd0,     6'd0,  1'b0, 21'd0,     6'd0,  1'b0},
    '{CMD_SOLVE, 6'd0,  16'd0,     6'd0,  1'b1, 21'd0,     6'd0,  1'b1},
    '{CMD_SOLVE, 6'd0,  16'd0,     6'd2,  1'b0, 21'd0,     6'd0,  1'b0}
  };

  rod_cutting_optimizer_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .price_index_i  (price_index_i),
    .price_value_i  (price_value_i),
    .rod_length_i   (rod_length_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .revenue_o      (revenue_o),
    .piece_length_o (piece_length_o),
    .last_o         (last_o)
  );

  always #4 clk_i = ~clk_i;

  // Run guard: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d pieces still expected", cycle_count,
               pending_cuts.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("[%0d] MISMATCH: %s", cycle_count, what);
    error_count++;
  endtask

  // Fill the revenue and first-cut tables bottom up for lengths 1..len. Each length starts
  // its search afresh at a first cut of 1, sums saturate at the revenue width, and on a tie
  // the smaller first cut is kept.
  task automatic fill_cut_tables(input int len);
    logic [REV_W:0]          cand;
    logic [REV_W-1:0]        top;
    logic [PORT_PIECE_W-1:0] cut;
    best_rev[0] = '0;
    best_cut[0] = '0;
    for (int j = 1; j <= len; j++) begin
      top = '0;
      cut = 6'd1;
      for (int i = 1; i <= j; i++) begin
        cand = {1'b0, {(REV_W - PRICE_BITS){1'b0}}, price_copy[i]} + {1'b0, best_rev[j - i]};
        if (cand > {1'b0, REV_MAX}) begin
          cand = {1'b0, REV_MAX};
        end
        if (i == 1 || cand[REV_W-1:0] > top) begin
          top = cand[REV_W-1:0];
          cut = PORT_PIECE_W'(i);
        end
      end
      best_rev[j] = top;
      best_cut[j] = cut;
    end
  endtask

  // Apply one accepted item to the bench state and queue the pieces it must produce.
  task automatic predict_cuts(input rod_item_t item);
    int               len;
    int               piece;
    int               n;
    logic [REV_W-1:0] rev;
    if (item.op == CMD_LOAD) begin
      if (item.idx >= 1 && item.idx <= MAX_LEN) begin
        price_copy[item.idx] = item.val[PRICE_BITS-1:0];
        loads_sent++;
      end else begin
        ignored_sent++;
      end
    end else begin
      solves_sent++;
      if (item.typed) begin
        pending_cuts.push_back('{item.want_rev, item.want_piece, item.want_last});
      end else begin
        len = (item.len > MAX_LEN) ? MAX_LEN : int'(item.len);
        if (len == 0) begin
          pending_cuts.push_back('{'0, '0, 1'b1});
        end else begin
          fill_cut_tables(len);
          rev = best_rev[len];
          n = 0;
          while (len > 0 && n < MAX_RESULTS) begin
            piece = int'(best_cut[len]);
            if (piece == 0 || piece > len) begin
              piece = len;
            end
            len -= piece;
            pending_cuts.push_back('{rev, PORT_PIECE_W'(piece),
                                     (len == 0 || n + 1 == MAX_RESULTS)});
            n++;
          end
        end
      end
    end
  endtask

  // Present one item at a falling edge, optionally after an idle burst, and hold it
  // until a rising edge sees ready. Returns at the falling edge after acceptance.
  task automatic send_item(input rod_item_t item);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(99, 0) < gap_pct) begin
      gap = $urandom_range(10, 1);
    end
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    op_i          = item.op;
    price_index_i = item.idx;
    price_value_i = item.val;
    rod_length_i  = item.len;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    predict_cuts(item);
    @(negedge clk_i);
  endtask

  // Random item: mostly in-range loads and short solves, a few long or saturating solves,
  // and some loads that the block ignores.
  function automatic rod_item_t random_item();
    rod_item_t item;
    int        kind;
    int        sel;
    item     = '0;
    item.idx = PORT_IDX_W'($urandom_range(63, 0));
    item.val = PORT_VAL_W'($urandom);
    item.len = PORT_LEN_W'($urandom_range(63, 0));
    kind     = $urandom_range(99, 0);
    if (kind < 8) begin
      item.op  = CMD_LOAD;
      item.idx = ($urandom_range(3, 0) == 0) ? 6'd0 : PORT_IDX_W'($urandom_range(63, 33));
    end else if (kind < 48) begin
      item.op  = CMD_LOAD;
      // Favor short piece lengths so that most solves see fresh prices.
      item.idx = ($urandom_range(1, 0) == 0) ? PORT_IDX_W'($urandom_range(10, 1))
                                             : PORT_IDX_W'($urandom_range(32, 1));
      sel = $urandom_range(9, 0);
      if (sel < 4) begin
        item.val = PORT_VAL_W'($urandom_range(15, 0));
      end else if (sel == 4) begin
        item.val = '0;
      end else if (sel == 5) begin
        item.val = '1;
      end
    end else begin
      item.op = CMD_SOLVE;
      sel     = $urandom_range(99, 0);
      if (sel < 70) begin
        item.len = PORT_LEN_W'($urandom_range(10, 0));
      end else if (sel < 90) begin
        item.len = PORT_LEN_W'($urandom_range(24, 11));
      end else if (sel < 97) begin
        item.len = PORT_LEN_W'($urandom_range(32, 25));
      end else begin
        item.len = PORT_LEN_W'($urandom_range(63, 33));
      end
    end
    return item;
  endfunction

  // Output side: ready is dropped in random stall bursts while stalling is enabled.
  initial begin
    int hold;
    hold        = 0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!quiet && hold > 0) begin
        out_ready_i = 1'b0;
        hold--;
      end else if (!quiet && $urandom_range(99, 0) < stall_pct) begin
        out_ready_i = 1'b0;
        hold = $urandom_range(10, 1) - 1;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // Every accepted piece is compared field by field with the oldest expectation.
  always @(posedge clk_i) begin
    cut_piece_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      pieces_seen++;
      if (pending_cuts.size() == 0) begin
        report_mismatch($sformatf("unexpected piece rev=%0d len=%0d last=%0b",
                                  revenue_o, piece_length_o, last_o));
      end else begin
        want = pending_cuts.pop_front();
        if (revenue_o !== want.revenue) begin
          report_mismatch($sformatf("revenue %0d, expected %0d", revenue_o, want.revenue));
        end
        if (piece_length_o !== want.piece) begin
          report_mismatch($sformatf("piece_length %0d, expected %0d",
                                    piece_length_o, want.piece));
        end
        if (last_o !== want.last) begin
          report_mismatch($sformatf("last %0b, expected %0b", last_o, want.last));
        end
      end
    end
  end

  initial begin
    rod_item_t item;
    int        counted;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    op_i          = 1'b0;
    price_index_i = '0;
    price_value_i = '0;
    rod_length_i  = '0;
    for (int k = 1; k <= MAX_LEN; k++) begin
      price_copy[k] = '0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part with light pressure on both sides.
    gap_pct   = 20;
    stall_pct = 20;
    for (int k = 0; k < N_DIRECTED; k++) begin
      send_item(directed_rows[k]);
    end

    // Random part. Idling intensity changes every 40 items, including stretches with
    // none; the closing stretch runs with both sides always ready.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 40 == 0) begin
        case ($urandom_range(2, 0))
          0: begin
            gap_pct   = 0;
            stall_pct = 0;
          end
          1: begin
            gap_pct   = 20;
            stall_pct = 15;
          end
          default: begin
            gap_pct   = 50;
            stall_pct = 40;
          end
        endcase
      end
      quiet = (counted >= RANDOM_ITEMS - QUIET_ITEMS);
      item  = random_item();
      send_item(item);
      if (!(item.op == CMD_LOAD && (item.idx == 0 || item.idx > MAX_LEN))) begin
        counted++;
      end
    end
    in_valid_i = 1'b0;

    while (pending_cuts.size() != 0) begin
      @(posedge clk_i);
    end
    // Leave room for a stray piece to show up after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d price loads, %0d ignored loads and %0d solves; %0d pieces checked.",
             loads_sent, ignored_sent, solves_sent, pieces_seen);
    $display("Mismatches: %0d, run length %0d cycles.", error_count, cycle_count);
    if (error_count == 0 && pending_cuts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
src/rcut_pkg.sv
src/rcut_front.sv
src/rcut_fifo.sv
src/rcut_engine.sv
src/rod_cutting_optimizer_unit.sv
dv/rod_cutting_optimizer_unit_test.sv
